@@ sv/rrn_pkg.sv @@
package rrn_pkg;

  typedef enum logic [1:0] {
    OP_TRAIN = 2'd0,
    OP_VOTE  = 2'd1,
    OP_FIT   = 2'd2,
    OP_APPLY = 2'd3
  } op_e;

  localparam int unsigned CfgW     = 48;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CountW   = 24;
  localparam int unsigned SumW     = 48;
  localparam int unsigned TargetW  = 32;
  localparam int unsigned PosW     = 6;
  localparam int unsigned MinW     = 5;

  localparam logic [CfgIdxW-1:0] REG_TABLE    = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_MIN_ZERO = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_MIN_ONE  = 2'd2;

  localparam logic [CountW-1:0] COUNT_MAX = {CountW{1'b1}};
  localparam logic signed [SumW-1:0] SUM_MAX = {1'b0, {(SumW-1){1'b1}}};
  localparam logic signed [SumW-1:0] SUM_MIN = {1'b1, {(SumW-1){1'b0}}};

  // datapath commands
  typedef enum logic [2:0] {
    CMD_NONE   = 3'd0,
    CMD_READ   = 3'd1,
    CMD_UPDATE = 3'd2,
    CMD_WREAD  = 3'd3,
    CMD_DIV    = 3'd4,
    CMD_WWRITE = 3'd5
  } cmd_e;

  typedef struct packed {
    cmd_e cmd;
    logic load;
    logic clr_walk;
  } ctl_t;

  typedef struct packed {
    logic walk_last;
    logic div_done;
    logic walk_valid;
  } sts_t;

  function automatic logic signed [SumW-1:0] sat_add(
    input logic signed [SumW-1:0] a,
    input logic signed [SumW-1:0] b
  );
    logic signed [SumW:0] s;
    s = {a[SumW-1], a} + {b[SumW-1], b};
    if (s[SumW] != s[SumW-1]) return s[SumW] ? SUM_MIN : SUM_MAX;
    return s[SumW-1:0];
  endfunction

endpackage

@@ sv/rrn_if.sv @@
interface rrn_in_if;
  logic valid;
  logic ready;
  logic [1:0] operation;
  logic [63:0] image_bits;
  logic signed [31:0] target_value;
  modport source (output valid, operation, image_bits, target_value, input ready);
  modport sink (input valid, operation, image_bits, target_value, output ready);
endinterface

interface rrn_out_if;
  logic valid;
  logic ready;
  logic [23:0] vote_count;
  logic signed [47:0] vote_sum;
  logic below_minimum;
  modport source (output valid, vote_count, vote_sum, below_minimum, input ready);
  modport sink (input valid, vote_count, vote_sum, below_minimum, output ready);
endinterface

@@ sv/regression_ram_node.sv @@
// One regression RAM node. Each request forms a TUPLE_BITS address from
// configured image bit positions. Train, vote and fit accumulation step through
// accept, entry read, and result with write-back on the output handshake.
// Apply fit walks all 2^TUPLE_BITS entries; each valid entry waits on the
// bit-serial 48-bit divider before its write-back.
module regression_ram_node #(
  parameter int unsigned TUPLE_BITS = 8,
  parameter int unsigned IMAGE_BITS = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  rrn_in_if.sink in_if,
  rrn_out_if.source out_if,
  input  logic cfg_we_i,
  input  logic [rrn_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [rrn_pkg::CfgW-1:0] cfg_data_i
);
  logic [rrn_pkg::CfgW-1:0] table_q;
  logic [rrn_pkg::MinW-1:0] min_zero_q, min_one_q;
  rrn_pkg::ctl_t ctl;
  rrn_pkg::sts_t sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_q <= '0;
      min_zero_q <= '0;
      min_one_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rrn_pkg::REG_TABLE:    table_q <= cfg_data_i;
        rrn_pkg::REG_MIN_ZERO: min_zero_q <= cfg_data_i[rrn_pkg::MinW-1:0];
        rrn_pkg::REG_MIN_ONE:  min_one_q <= cfg_data_i[rrn_pkg::MinW-1:0];
        default: ;
      endcase
    end
  end

  rrn_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid),
    .in_ready_o(in_if.ready),
    .op_i(in_if.operation),
    .out_valid_o(out_if.valid),
    .out_ready_i(out_if.ready),
    .ctl_o(ctl),
    .sts_i(sts)
  );

  rrn_datapath #(.TUPLE_BITS(TUPLE_BITS), .IMAGE_BITS(IMAGE_BITS)) u_dp (
    .clk_i, .rst_ni,
    .ctl_i(ctl),
    .sts_o(sts),
    .op_i(in_if.operation),
    .image_i(in_if.image_bits[IMAGE_BITS-1:0]),
    .target_i(in_if.target_value),
    .table_i(table_q),
    .min_zero_i(min_zero_q),
    .min_one_i(min_one_q),
    .count_o(out_if.vote_count),
    .sum_o(out_if.vote_sum),
    .below_o(out_if.below_minimum)
  );

  a_ready_when_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> !in_if.ready) else $error("input taken while result pending");
  a_result_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_if.valid && in_if.ready && in_if.operation != rrn_pkg::OP_APPLY) |=> ##1 out_if.valid)
    else $error("short request result late");
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && !out_if.ready) |=> out_if.valid) else $error("result dropped");
endmodule

@@ sv/rrn_div.sv @@
module rrn_div (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  logic signed [rrn_pkg::SumW-1:0] num_i,
  input  logic [rrn_pkg::CountW-1:0] den_i,
  output logic done_o,
  output logic signed [rrn_pkg::SumW-1:0] quo_o
);
  localparam int unsigned W = rrn_pkg::SumW;
  localparam int unsigned CntW = $clog2(W + 1);

  logic [W-1:0] q_q, q_d;
  logic [rrn_pkg::CountW:0] r_q, r_d;
  logic [rrn_pkg::CountW-1:0] den_q, den_d;
  logic neg_q, neg_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic busy_q, busy_d;
  logic [rrn_pkg::CountW:0] trial;
  logic [W-1:0] mag;

  assign mag = num_i[W-1] ? W'(-num_i) : W'(num_i);
  assign trial = {r_q[rrn_pkg::CountW-1:0], q_q[W-1]};

  always_comb begin
    q_d = q_q;
    r_d = r_q;
    den_d = den_q;
    neg_d = neg_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      q_d = mag;
      r_d = '0;
      den_d = den_i;
      neg_d = num_i[W-1];
      cnt_d = CntW'(W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        r_d = trial - {1'b0, den_q};
        q_d = {q_q[W-2:0], 1'b1};
      end else begin
        r_d = trial;
        q_d = {q_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
    r_q <= r_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  assign done_o = busy_q && (cnt_q == CntW'(1));
  assign quo_o = neg_q ? -$signed(q_d) : $signed(q_d);
endmodule

@@ sv/rrn_datapath.sv @@
module rrn_datapath #(
  parameter int unsigned TUPLE_BITS = 8,
  parameter int unsigned IMAGE_BITS = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  rrn_pkg::ctl_t ctl_i,
  output rrn_pkg::sts_t sts_o,
  input  logic [1:0] op_i,
  input  logic [IMAGE_BITS-1:0] image_i,
  input  logic signed [rrn_pkg::TargetW-1:0] target_i,
  input  logic [rrn_pkg::CfgW-1:0] table_i,
  input  logic [rrn_pkg::MinW-1:0] min_zero_i,
  input  logic [rrn_pkg::MinW-1:0] min_one_i,
  output logic [rrn_pkg::CountW-1:0] count_o,
  output logic signed [rrn_pkg::SumW-1:0] sum_o,
  output logic below_o
);
  localparam int unsigned Depth = 1 << TUPLE_BITS;
  localparam int unsigned OnesW = $clog2(TUPLE_BITS + 1);
  localparam int unsigned IdxW = $clog2(IMAGE_BITS);
  localparam int unsigned SlotN = rrn_pkg::CfgW / rrn_pkg::PosW;

  logic [Depth-1:0] valid_q;
  logic [rrn_pkg::CountW-1:0] cnt_mem [Depth];
  logic signed [rrn_pkg::SumW-1:0] sum_mem [Depth];
  logic signed [rrn_pkg::SumW-1:0] fit_mem [Depth];

  logic [TUPLE_BITS-1:0] addr_d, addr_q, walk_q, mem_addr;
  logic [OnesW-1:0] ones_d;
  logic below_d, below_q;
  logic [1:0] op_q;
  logic signed [rrn_pkg::SumW-1:0] tgt_q;
  logic [rrn_pkg::CountW-1:0] rd_cnt_q;
  logic signed [rrn_pkg::SumW-1:0] rd_sum_q, rd_fit_q, quo;
  logic hit_q;
  logic div_start_q;

  always_comb begin
    logic [rrn_pkg::PosW-1:0] pos;
    addr_d = '0;
    ones_d = '0;
    for (int i = 0; i < TUPLE_BITS; i++) begin
      pos = (i < SlotN) ? table_i[i*rrn_pkg::PosW +: rrn_pkg::PosW] : '0;
      if (32'(pos) < IMAGE_BITS) addr_d[i] = image_i[pos[IdxW-1:0]];
      ones_d = ones_d + OnesW'(addr_d[i]);
    end
    below_d = (rrn_pkg::MinW'(ones_d) < min_one_i) ||
              (rrn_pkg::MinW'(OnesW'(TUPLE_BITS) - ones_d) < min_zero_i);
  end

  assign mem_addr = (ctl_i.cmd == rrn_pkg::CMD_WREAD || ctl_i.cmd == rrn_pkg::CMD_DIV ||
                     ctl_i.cmd == rrn_pkg::CMD_WWRITE) ? walk_q : addr_q;

  rrn_div u_div (
    .clk_i, .rst_ni,
    .start_i(div_start_q),
    .num_i(rd_fit_q),
    .den_i(rd_cnt_q),
    .done_o(sts_o.div_done),
    .quo_o(quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      walk_q <= '0;
      div_start_q <= 1'b0;
    end else begin
      div_start_q <= (ctl_i.cmd == rrn_pkg::CMD_WREAD) && valid_q[walk_q];
      if (ctl_i.clr_walk) walk_q <= '0;
      else if (ctl_i.cmd == rrn_pkg::CMD_WWRITE ||
               (ctl_i.cmd == rrn_pkg::CMD_WREAD && !valid_q[walk_q])) walk_q <= walk_q + 1'b1;
      if (ctl_i.cmd == rrn_pkg::CMD_UPDATE && op_q == rrn_pkg::OP_TRAIN) valid_q[addr_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      addr_q <= addr_d;
      below_q <= below_d;
      op_q <= op_i;
      tgt_q <= rrn_pkg::SumW'(target_i);
    end
    if (ctl_i.cmd == rrn_pkg::CMD_READ || ctl_i.cmd == rrn_pkg::CMD_WREAD) begin
      hit_q <= valid_q[mem_addr];
      rd_cnt_q <= cnt_mem[mem_addr];
      rd_sum_q <= sum_mem[mem_addr];
      rd_fit_q <= fit_mem[mem_addr];
    end
    if (ctl_i.cmd == rrn_pkg::CMD_UPDATE) begin
      if (op_q == rrn_pkg::OP_TRAIN) begin
        if (!hit_q) begin
          cnt_mem[mem_addr] <= rrn_pkg::CountW'(1);
          sum_mem[mem_addr] <= tgt_q;
          fit_mem[mem_addr] <= '0;
        end else begin
          cnt_mem[mem_addr] <= (rd_cnt_q == rrn_pkg::COUNT_MAX) ? rd_cnt_q : rd_cnt_q + 1'b1;
          sum_mem[mem_addr] <= rrn_pkg::sat_add(rd_sum_q, tgt_q);
        end
      end else if (op_q == rrn_pkg::OP_FIT && hit_q) begin
        fit_mem[mem_addr] <= rrn_pkg::sat_add(rd_fit_q, tgt_q);
      end
    end
    if (ctl_i.cmd == rrn_pkg::CMD_WWRITE) begin
      if (rd_cnt_q != '0) sum_mem[mem_addr] <= rrn_pkg::sat_add(rd_sum_q, quo);
      fit_mem[mem_addr] <= '0;
    end
  end

  assign sts_o.walk_last = (walk_q == {TUPLE_BITS{1'b1}});
  assign sts_o.walk_valid = valid_q[walk_q];

  always_comb begin
    count_o = '0;
    sum_o = '0;
    below_o = 1'b0;
    if (op_q == rrn_pkg::OP_VOTE) begin
      if (below_q) below_o = 1'b1;
      else if (hit_q) begin
        count_o = rd_cnt_q;
        sum_o = rd_sum_q;
      end
    end
  end
endmodule

@@ sv/rrn_ctrl.sv @@
module rrn_ctrl (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic [1:0] op_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output rrn_pkg::ctl_t ctl_o,
  input  rrn_pkg::sts_t sts_i
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RMW  = 3'd1;
  localparam logic [2:0] S_WRD  = 3'd2;
  localparam logic [2:0] S_WDIV = 3'd3;
  localparam logic [2:0] S_WWR  = 3'd4;
  localparam logic [2:0] S_RES  = 3'd5;

  logic [2:0] state_q, state_d;
  logic accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == S_RES);

  always_comb begin
    state_d = state_q;
    ctl_o = '{cmd: rrn_pkg::CMD_NONE, load: 1'b0, clr_walk: 1'b0};
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          ctl_o.load = 1'b1;
          ctl_o.clr_walk = 1'b1;
          state_d = (op_i == rrn_pkg::OP_APPLY) ? S_WRD : S_RMW;
        end
      end
      S_RMW: begin
        ctl_o.cmd = rrn_pkg::CMD_READ;
        state_d = S_RES;
      end
      S_WRD: begin
        ctl_o.cmd = rrn_pkg::CMD_WREAD;
        if (sts_i.walk_valid) state_d = S_WDIV;
        else if (sts_i.walk_last) state_d = S_RES;
      end
      S_WDIV: begin
        ctl_o.cmd = rrn_pkg::CMD_DIV;
        if (sts_i.div_done) begin
          ctl_o.cmd = rrn_pkg::CMD_WWRITE;
          state_d = sts_i.walk_last ? S_RES : S_WRD;
        end
      end
      S_WWR: state_d = S_RES;
      S_RES: begin
        if (out_ready_i) begin
          ctl_o.cmd = rrn_pkg::CMD_UPDATE;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end
endmodule

@@ dv/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Depth = 256;
  localparam longint CycleLimit = 3000000;
  localparam longint S48Max = 64'sd140737488355327;
  localparam longint S48Min = -64'sd140737488355328;

  typedef struct {
    rrn_pkg::op_e op;
    logic [63:0] image;
    logic signed [31:0] target;
  } request_t;

  typedef struct {
    logic [rrn_pkg::CountW-1:0] count;
    logic signed [rrn_pkg::SumW-1:0] sum;
    logic below;
  } vote_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [rrn_pkg::CfgIdxW-1:0] cfg_idx_i = rrn_pkg::REG_TABLE;
  logic [rrn_pkg::CfgW-1:0] cfg_data_i = '0;

  rrn_in_if in_if ();
  rrn_out_if out_if ();

  regression_ram_node u_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_if(in_if.sink),
    .out_if(out_if.source),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  // predictor state
  logic [47:0] sel_table;
  logic [4:0] min_zero, min_one;
  bit node_valid[Depth];
  longint node_count[Depth];
  longint node_sum[Depth];
  longint node_fit[Depth];

  request_t pend_q[$];
  vote_t vote_q[$];
  bit taken;
  bit no_idle;
  bit hold_done;
  int hold_cnt;
  int n_acc, n_res, n_err, n_apply, n_below;
  longint cycles;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.operation = rrn_pkg::OP_TRAIN;
    in_if.image_bits = '0;
    in_if.target_value = '0;
    out_if.ready = 1'b0;
  end

  function automatic longint sat48(longint v);
    if (v > S48Max) return S48Max;
    if (v < S48Min) return S48Min;
    return v;
  endfunction

  function automatic vote_t node_predict(request_t r);
    vote_t v;
    int unsigned addr, ones;
    logic [5:0] pos;
    v.count = '0;
    v.sum = '0;
    v.below = 1'b0;
    addr = 0;
    ones = 0;
    for (int i = 0; i < 8; i++) begin
      pos = sel_table[6*i +: 6];
      if (r.image[pos]) begin
        addr |= 1 << i;
        ones++;
      end
    end
    case (r.op)
      rrn_pkg::OP_TRAIN: begin
        if (!node_valid[addr]) begin
          node_valid[addr] = 1'b1;
          node_count[addr] = 1;
          node_sum[addr] = longint'(r.target);
          node_fit[addr] = 0;
        end else begin
          if (node_count[addr] < 16777215) node_count[addr]++;
          node_sum[addr] = sat48(node_sum[addr] + longint'(r.target));
        end
      end
      rrn_pkg::OP_VOTE: begin
        if (ones < min_one || (8 - ones) < min_zero) begin
          v.below = 1'b1;
        end else if (node_valid[addr]) begin
          v.count = node_count[addr][23:0];
          v.sum = node_sum[addr][47:0];
        end
      end
      rrn_pkg::OP_FIT: begin
        if (node_valid[addr]) node_fit[addr] = sat48(node_fit[addr] + longint'(r.target));
      end
      default: begin
        for (int k = 0; k < Depth; k++) begin
          if (node_valid[k]) begin
            if (node_count[k] != 0) node_sum[k] = sat48(node_sum[k] + node_fit[k] / node_count[k]);
            node_fit[k] = 0;
          end
        end
      end
    endcase
    return v;
  endfunction

  // monitor: acceptance, prediction, checking
  always @(posedge clk_i) begin
    vote_t e;
    request_t r;
    taken = 1'b0;
    cycles++;
    if (rst_ni && in_if.valid && in_if.ready) begin
      r = pend_q.pop_front();
      if (r.op == rrn_pkg::OP_APPLY) n_apply++;
      vote_q.push_back(node_predict(r));
      n_acc++;
      taken = 1'b1;
    end
    if (rst_ni && out_if.valid && out_if.ready) begin
      n_res++;
      if (out_if.below_minimum) n_below++;
      if (vote_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected result count=%0d sum=%0d below=%0b",
                                  out_if.vote_count, out_if.vote_sum, out_if.below_minimum);
      end else begin
        e = vote_q.pop_front();
        if (out_if.vote_count !== e.count || out_if.vote_sum !== e.sum ||
            out_if.below_minimum !== e.below) begin
          n_err++;
          if (n_err <= 10)
            $display("mismatch #%0d: exp count=%0d sum=%0d below=%0b got count=%0d sum=%0d below=%0b",
                     n_res, e.count, e.sum, e.below,
                     out_if.vote_count, out_if.vote_sum, out_if.below_minimum);
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && (!in_if.valid || taken)) begin
      if (pend_q.size() != 0 && (no_idle || $urandom_range(99) >= 36)) begin
        in_if.valid <= 1'b1;
        in_if.operation <= pend_q[0].op;
        in_if.image_bits <= pend_q[0].image;
        in_if.target_value <= pend_q[0].target;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (!hold_done && n_acc >= 300) begin
      hold_done <= 1'b1;
      hold_cnt <= 400;
      out_if.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= rst_ni && (no_idle || $urandom_range(99) >= 36);
    end
  end

  always @(posedge clk_i) begin
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic write_reg(logic [rrn_pkg::CfgIdxW-1:0] idx, logic [rrn_pkg::CfgW-1:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic configure(logic [47:0] tbl, logic [4:0] mz, logic [4:0] mo);
    while (pend_q.size() != 0 || vote_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    write_reg(rrn_pkg::REG_TABLE, tbl);
    write_reg(rrn_pkg::REG_MIN_ZERO, rrn_pkg::CfgW'(mz));
    write_reg(rrn_pkg::REG_MIN_ONE, rrn_pkg::CfgW'(mo));
    sel_table = tbl;
    min_zero = mz;
    min_one = mo;
  endtask

  task automatic queue_req(rrn_pkg::op_e op, logic [63:0] image, logic [31:0] target);
    request_t r;
    r.op = op;
    r.image = image;
    r.target = target;
    pend_q.push_back(r);
  endtask

  task automatic queue_random(int n);
    int unsigned w;
    rrn_pkg::op_e op;
    logic [63:0] img;
    logic [31:0] tgt;
    for (int i = 0; i < n; i++) begin
      w = $urandom_range(999);
      op = w < 400 ? rrn_pkg::OP_TRAIN : w < 750 ? rrn_pkg::OP_VOTE :
           w < 992 ? rrn_pkg::OP_FIT : rrn_pkg::OP_APPLY;
      img = {$urandom, $urandom};
      case ($urandom_range(3))
        0: tgt = $urandom;
        1: tgt = $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
        default: tgt = 32'($signed($urandom_range(200000)) - 100000);
      endcase
      queue_req(op, img, tgt);
    end
  endtask

  initial begin
    logic [47:0] ident;
    ident = '0;
    for (int i = 0; i < 8; i++) ident[6*i +: 6] = 6'(i);
    sel_table = '0;
    min_zero = '0;
    min_one = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    configure(ident, 5'd2, 5'd2);
    queue_req(rrn_pkg::OP_VOTE, 64'h0, 32'h0);
    queue_req(rrn_pkg::OP_VOTE, 64'h0f, 32'h0);
    queue_req(rrn_pkg::OP_FIT, 64'h0f, 32'd5);
    queue_req(rrn_pkg::OP_APPLY, 64'h0, 32'h0);
    queue_req(rrn_pkg::OP_TRAIN, 64'h0f, 32'h7fffffff);
    queue_req(rrn_pkg::OP_TRAIN, 64'h0f, 32'h80000000);
    queue_req(rrn_pkg::OP_TRAIN, 64'h0f, 32'd3);
    queue_req(rrn_pkg::OP_VOTE, 64'h0f, 32'h0);
    queue_req(rrn_pkg::OP_FIT, 64'h0f, -32'sd7);
    queue_req(rrn_pkg::OP_FIT, 64'h0f, 32'h7fffffff);
    queue_req(rrn_pkg::OP_APPLY, 64'h0, 32'h0);
    queue_req(rrn_pkg::OP_VOTE, 64'h0f, 32'h0);
    queue_req(rrn_pkg::OP_TRAIN, '1, 32'h80000000);
    queue_req(rrn_pkg::OP_VOTE, '1, 32'h0);
    queue_req(rrn_pkg::OP_TRAIN, 64'h03, -32'sd1);
    queue_req(rrn_pkg::OP_FIT, 64'h03, -32'sd5);
    queue_req(rrn_pkg::OP_APPLY, '1, 32'hffffffff);
    queue_req(rrn_pkg::OP_VOTE, 64'h03, 32'h0);
    queue_req(rrn_pkg::OP_VOTE, 64'hffffffff_ffffff03, 32'h0);
    queue_req(rrn_pkg::OP_FIT, 64'hffff_0000_0000_0000, 32'h1);

    configure(48'({$urandom, $urandom}), 5'd0, 5'd0);
    queue_random(400);
    configure('0, 5'd0, 5'd0);
    no_idle = 1'b1;
    queue_random(300);
    configure('0, 5'd16, 5'd16);
    queue_random(100);
    while (pend_q.size() != 0) @(posedge clk_i);
    no_idle = 1'b0;
    configure('1, 5'd0, 5'd8);
    queue_random(200);
    configure(48'({$urandom, $urandom}), 5'($urandom_range(5)), 5'($urandom_range(5)));
    queue_random(500);
    configure(48'({$urandom, $urandom}), 5'($urandom_range(31)), 5'($urandom_range(31)));
    queue_random(500);

    while (pend_q.size() != 0 || vote_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (vote_q.size() != 0) n_err++;
    $display("%0d requests (%0d apply fit) over 7 register settings, %0d results, %0d below min",
             n_acc, n_apply, n_res, n_below);
    $display("%0d errors in %0d cycles", n_err, cycles);
    if (n_err == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

@@ sim.f @@
sv/rrn_pkg.sv
sv/rrn_if.sv
sv/rrn_div.sv
sv/rrn_datapath.sv
sv/rrn_ctrl.sv
sv/regression_ram_node.sv
dv/testbench.sv
